// ===== hw/rtl/pcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpu_pkg
// Shared types, constants and reset layout for the pixel channel pack/unpack.
// ----------------------------------------------------------------------------
package pcpu_pkg;

	localparam int unsigned CH_COUNT   = 4;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned COMP_W     = 8;
	localparam int unsigned WIDTH_W    = 5;
	localparam int unsigned SHIFT_W    = 6;
	localparam int unsigned MAX_FIELD  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned DEF_DEPTH  = 2;

	localparam logic [WIDTH_W-1:0] RST_WIDTH [CH_COUNT] = '{5'd8, 5'd8, 5'd8, 5'd8};
	localparam logic [SHIFT_W-1:0] RST_SHIFT [CH_COUNT] = '{6'd0, 6'd8, 6'd16, 6'd24};

	typedef enum logic {
		REQ_UNPACK = 1'b0,
		REQ_PACK   = 1'b1
	} req_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic [SHIFT_W-1:0] shift;
	} chan_cfg_t;

	// saturated field width, 0..16
	function automatic logic [4:0] sat_width(input logic [WIDTH_W-1:0] w);
		sat_width = (w > WIDTH_W'(MAX_FIELD)) ? 5'(MAX_FIELD) : w;
	endfunction

	// 2^w - 1 for w in 0..16
	function automatic logic [MAX_FIELD-1:0] field_mask(input logic [4:0] w);
		field_mask = MAX_FIELD'((17'd1 << w) - 17'd1);
	endfunction

endpackage

// ===== hw/rtl/pcpu_chan.sv =====
// ----------------------------------------------------------------------------
// pcpu_chan
// One color channel: four-stage pack and unpack datapath with stall enable.
// s1: extract raw field; s2: products; s3: pack divide by 255, upper four
// unpack quotient bits; s4: shift packed field, lower four quotient bits
// ----------------------------------------------------------------------------
module pcpu_chan
	import pcpu_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  chan_cfg_t             cfg,
	input  logic [WORD_W-1:0]     word,
	input  logic [COMP_W-1:0]     comp,
	output logic [WORD_W-1:0]     pack_word,
	output logic [COMP_W-1:0]     unpack_comp
);

	// stage 1: saturated width, max, raw field
	logic [MAX_FIELD-1:0] max_s1;
	logic [MAX_FIELD-1:0] raw_s1;
	logic [COMP_W-1:0]    comp_s1;
	logic [SHIFT_W-1:0]   shift_s1;
	logic                 zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			max_s1   <= field_mask(sat_width(cfg.width));
			raw_s1   <= MAX_FIELD'(word >> cfg.shift) & field_mask(sat_width(cfg.width));
			comp_s1  <= comp;
			shift_s1 <= cfg.shift;
			zero_s1  <= (cfg.width == '0);
		end
	end

	// stage 2: products, 24 bits each
	logic [23:0]          pprod_s2;
	logic [23:0]          uprod_s2;
	logic [MAX_FIELD-1:0] max_s2;
	logic [SHIFT_W-1:0]   shift_s2;
	logic                 zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pprod_s2 <= 24'(comp_s1) * 24'(max_s1);
			uprod_s2 <= 24'(raw_s1) * 24'd255;
			max_s2   <= max_s1;
			shift_s2 <= shift_s1;
			zero_s2  <= zero_s1;
		end
	end

	// stage 3: pack quotient by reciprocal of 255; unpack quotient is below
	// 256, so the divide by max is a restoring divide split into 4 + 4 bits
	logic [MAX_FIELD-1:0] pq_s3;
	logic [SHIFT_W-1:0]   shift_s3;
	logic                 zero_s3;
	logic [3:0]           uq_hi_s3;
	logic [23:0]          urem_s3;
	logic [MAX_FIELD-1:0] max_s3;

	logic [47:0] recip;
	logic [16:0] q_est;
	logic [23:0] r_est;
	logic [MAX_FIELD-1:0] pq_c;
	logic [3:0]  hi_c;
	logic [23:0] rem_c;
	logic [23:0] trial;

	always_comb begin
		// floor(x/255) for x < 2^24: x*0x10101 >> 24 then one correction
		recip = 48'(pprod_s2) * 48'h10101;
		q_est = 17'(recip >> 24);
		r_est = pprod_s2 - 24'(q_est) * 24'd255;
		pq_c  = (r_est >= 24'd255) ? MAX_FIELD'(q_est + 17'd1) : MAX_FIELD'(q_est);
		rem_c = uprod_s2;
		hi_c  = '0;
		for (int i = 7; i >= 4; i--) begin
			trial = 24'(max_s2) << i;
			if (rem_c >= trial) begin
				rem_c      = rem_c - trial;
				hi_c[i-4]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pq_s3    <= pq_c;
			shift_s3 <= shift_s2;
			zero_s3  <= zero_s2;
			uq_hi_s3 <= hi_c;
			urem_s3  <= rem_c;
			max_s3   <= max_s2;
		end
	end

	// stage 4: shift packed field; low quotient bits of unpack
	logic [3:0]  lo_c;
	logic [23:0] rem2;
	logic [23:0] trial2;

	always_comb begin
		rem2 = urem_s3;
		lo_c = '0;
		for (int i = 3; i >= 0; i--) begin
			trial2 = 24'(max_s3) << i;
			if (rem2 >= trial2) begin
				rem2    = rem2 - trial2;
				lo_c[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pack_word   <= zero_s3 ? '0 : (WORD_W'(pq_s3) << shift_s3);
			unpack_comp <= zero_s3 ? '0 : {uq_hi_s3, lo_c};
		end
	end

endmodule

// ===== hw/rtl/pixel_channel_pack_unpack.sv =====
// ----------------------------------------------------------------------------
// pixel_channel_pack_unpack
// Converts between 8-bit RGBA components and a configurable packed pixel word.
// ----------------------------------------------------------------------------
// One transaction in, one out. The datapath is a four-stage pipeline
// (field extract, multiply, reciprocal divide / upper quotient bits, shift /
// lower quotient bits) and accepts a transaction every clock while s_tready is
// high; a result passes the four pipeline stages and the output FIFO register
// before it can be taken. A six-entry output FIFO (pipeline depth plus two)
// keeps full rate under backpressure. Registers may be written only when idle.
module pixel_channel_pack_unpack
	import pcpu_pkg::*;
#(
	parameter int unsigned SKID_DEPTH = DEF_DEPTH
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [63:0] packed_in, [71:64] red_in, [79:72] green_in, [87:80] blue_in,
	// [95:88] alpha_in
	input  logic [95:0]           s_tdata,
	input  logic                  s_tuser,   // [0] req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [63:0] packed_out, [71:64] red_out, [79:72] green_out, [87:80] blue_out,
	// [95:88] alpha_out
	output logic [95:0]           m_tdata
);

	localparam int unsigned STAGES = 4;
	localparam int unsigned CNT_W  = $clog2(STAGES + SKID_DEPTH + 1);

	chan_cfg_t cfg_q [CH_COUNT];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH_COUNT; c++) begin
				cfg_q[c].width <= RST_WIDTH[c];
				cfg_q[c].shift <= RST_SHIFT[c];
			end
		end else if (cfg_valid && !cfg_index[CFG_IDX_W]) begin
			if (cfg_index[0])
				cfg_q[cfg_index[CFG_IDX_W-1:1]].shift <= cfg_data[SHIFT_W-1:0];
			else
				cfg_q[cfg_index[CFG_IDX_W-1:1]].width <= cfg_data[WIDTH_W-1:0];
		end
	end

	// Pipeline always advances; a credit count bounds items in flight to
	// the skid FIFO's free space so nothing is lost.
	logic             in_fire;
	logic             out_fire;
	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] pack_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_fire = s_tvalid && s_tready;
	assign s_tready = (cnt_q < CNT_W'(STAGES + SKID_DEPTH)) || out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			pack_q <= '0;
			cnt_q  <= '0;
		end else begin
			vld_q  <= {vld_q[STAGES-2:0], in_fire};
			pack_q <= {pack_q[STAGES-2:0], s_tuser == REQ_PACK};
			cnt_q  <= cnt_q + CNT_W'(in_fire) - CNT_W'(out_fire);
		end
	end

	logic [WORD_W-1:0] pw [CH_COUNT];
	logic [COMP_W-1:0] uc [CH_COUNT];

	for (genvar c = 0; c < CH_COUNT; c++) begin : g_ch
		pcpu_chan u_chan (
			.clk         (clk),
			.en          (1'b1),
			.cfg         (cfg_q[c]),
			.word        (s_tdata[WORD_W-1:0]),
			.comp        (s_tdata[WORD_W+COMP_W*c +: COMP_W]),
			.pack_word   (pw[c]),
			.unpack_comp (uc[c])
		);
	end

	logic        res_pack;
	logic [95:0] res;

	assign res_pack = pack_q[STAGES-1];
	always_comb begin
		if (res_pack)
			res = {32'd0, pw[0] | pw[1] | pw[2] | pw[3]};
		else
			res = {uc[3], uc[2], uc[1], uc[0], 64'd0};
	end

	// output skid FIFO
	localparam int unsigned PTR_W = (SKID_DEPTH + STAGES > 1) ?
		$clog2(SKID_DEPTH + STAGES) : 1;
	localparam int unsigned FDEPTH = SKID_DEPTH + STAGES;

	logic [95:0]      fifo_q [FDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fcnt_q;
	logic             push;

	assign push     = vld_q[STAGES-1];
	assign m_tvalid = fcnt_q != '0;
	assign out_fire = m_tvalid && m_tready;
	assign m_tdata  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fcnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(FDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (out_fire)
				rd_q <= (rd_q == PTR_W'(FDEPTH - 1)) ? '0 : rd_q + 1'b1;
			fcnt_q <= fcnt_q + CNT_W'(push) - CNT_W'(out_fire);
		end
	end

endmodule

// ===== hw/rtl/pcpu_checker.sv =====
// ----------------------------------------------------------------------------
// pcpu_checker
// Port-level checks for pixel_channel_pack_unpack, bound to the top level.
// ----------------------------------------------------------------------------
module pcpu_checker
	import pcpu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output changed on stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output dropped");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##5 m_tvalid) else $error("result missing");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[95:64] == '0) || (m_tdata[63:0] == '0))
		else $error("mixed result");

endmodule

bind pixel_channel_pack_unpack pcpu_checker u_pcpu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
